[hw/rtl/aopd_pkg.sv]
// aopd_pkg: shared types and constants for the adaptive onset pulse detector.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package aopd_pkg;

   // field widths
   localparam int LEVEL_W   = 16;
   localparam int TIME_W    = 32;
   localparam int TEMPO_W   = 12;
   localparam int MULT_W    = 12;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int PROD_W    = 32;
   localparam int COOL_W    = 8;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FAST_DROP   = 3'd0,
      CSR_SLOW_RISE   = 3'd1,
      CSR_PEAK_DECAY  = 3'd2,
      CSR_THR_MULT    = 3'd3,
      CSR_ONSET_FLOOR = 3'd4,
      CSR_MIN_LEVEL   = 3'd5
   } csr_idx_type;

   // configuration reset values
   localparam logic [LEVEL_W-1:0] FAST_DROP_RST   = 16'd19661;
   localparam logic [LEVEL_W-1:0] SLOW_RISE_RST   = 16'd1311;
   localparam logic [LEVEL_W-1:0] PEAK_DECAY_RST  = 16'd55706;
   localparam logic [MULT_W-1:0]  THR_MULT_RST    = 12'd512;
   localparam logic [LEVEL_W-1:0] ONSET_FLOOR_RST = 16'd6554;
   localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST   = 16'd1966;

   // cooldown: 150 ms at or below 60 BPM, 40 ms at or above 200 BPM,
   // 150 - ceil(11 * (tempo - 960) / 224) in between
   localparam logic [TEMPO_W-1:0] TEMPO_LO     = 12'd960;
   localparam logic [TEMPO_W-1:0] TEMPO_HI     = 12'd3200;
   localparam logic [COOL_W-1:0]  COOL_MAX     = 8'd150;
   localparam logic [COOL_W-1:0]  COOL_MIN     = 8'd40;
   localparam logic [14:0]        COOL_SLOPE   = 15'd11;
   localparam logic [14:0]        COOL_CEIL    = 15'd223;
   // 224 = 32 * 7; the divide by 7 is a multiply by ceil(2^16 / 7)
   localparam logic [23:0]        RECIP7       = 24'd9363;

   // baseline step rounds half up
   localparam logic [PROD_W-1:0]  ROUND_HALF   = 32'h0000_8000;

   typedef struct packed {
      logic [LEVEL_W-1:0] onset_value;
      logic [LEVEL_W-1:0] mic_level;
      logic [TIME_W-1:0]  time_ms;
      logic [TEMPO_W-1:0] tempo_bpm;
   } req_word_type;

   typedef struct packed {
      logic               pulse_fired;
      logic [LEVEL_W-1:0] pulse_strength;
      logic [LEVEL_W-1:0] baseline_level;
      logic [LEVEL_W-1:0] peak_level;
   } rsp_word_type;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MBASE = 5'b00010,
      ST_MPEAK = 5'b00100,
      ST_MTHR  = 5'b01000,
      ST_FIN   = 5'b10000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // latch the accepted word
      logic mul_base;   // |onset - baseline| * rate, cooldown, time check
      logic mul_peak;   // baseline update, peak * decay
      logic mul_thr;    // peak update, baseline * multiplier
      logic finish;     // threshold compare, result word, last pulse time
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_free;  // output register empty or being drained
   } status_type;

endpackage

[hw/rtl/aopd_if.sv]
// aopd_if: valid/ready channel interfaces for the request, response and
// register-write channels. Depends on aopd_pkg.

interface aopd_req_if import aopd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] onset_value;
   logic [LEVEL_W-1:0] mic_level;
   logic [TIME_W-1:0]  time_ms;
   logic [TEMPO_W-1:0] tempo_bpm;

   modport source (output valid, onset_value, mic_level, time_ms, tempo_bpm, input ready);
   modport sink   (input valid, onset_value, mic_level, time_ms, tempo_bpm, output ready);
endinterface

interface aopd_rsp_if import aopd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               pulse_fired;
   logic [LEVEL_W-1:0] pulse_strength;
   logic [LEVEL_W-1:0] baseline_level;
   logic [LEVEL_W-1:0] peak_level;

   modport source (output valid, pulse_fired, pulse_strength, baseline_level, peak_level,
                   input ready);
   modport sink   (input valid, pulse_fired, pulse_strength, baseline_level, peak_level,
                   output ready);
endinterface

interface aopd_csr_if import aopd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/aopd_ctrl.sv]
// aopd_ctrl: sequencer that steps one word through the shared multiplier.
// Depends on aopd_pkg; drives aopd_datapath through cmd_type.
module aopd_ctrl import aopd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   // take a new word when idle, or while the previous one retires
   always_comb begin
      req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_FIN) && status.slot_free);
      accept    = req_valid && req_ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_MBASE;
         ST_MBASE: state_in = ST_MPEAK;
         ST_MPEAK: state_in = ST_MTHR;
         ST_MTHR:  state_in = ST_FIN;
         ST_FIN: begin
            if (status.slot_free) begin
               state_in = accept ? ST_MBASE : ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd          = '0;
      cmd.load     = accept;
      cmd.mul_base = (state_ff == ST_MBASE);
      cmd.mul_peak = (state_ff == ST_MPEAK);
      cmd.mul_thr  = (state_ff == ST_MTHR);
      cmd.finish   = (state_ff == ST_FIN) && status.slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MBASE)
      else $error("accepted word did not start the multiply sequence");

   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) && !status.slot_free |=> state_ff == ST_FIN)
      else $error("result dropped while output register full");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.mul_base, cmd.mul_peak, cmd.mul_thr, cmd.finish}))
      else $error("more than one datapath step at once");

   a_load_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !(cmd.mul_base || cmd.mul_peak || cmd.mul_thr))
      else $error("load collides with a multiply step");
`endif

endmodule

[hw/rtl/aopd_datapath.sv]
// aopd_datapath: configuration registers, detector state, one shared 16x16
// multiplier and the output register. Depends on aopd_pkg.
module aopd_datapath import aopd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  req_word_type         req_word,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_word_type         rsp_word
);

   // configuration
   logic [LEVEL_W-1:0] fast_drop_ff, slow_rise_ff, peak_decay_ff;
   logic [LEVEL_W-1:0] onset_floor_ff, min_level_ff;
   logic [MULT_W-1:0]  thr_mult_ff;
   logic [LEVEL_W-1:0] fast_drop_in, slow_rise_in, peak_decay_in;
   logic [LEVEL_W-1:0] onset_floor_in, min_level_in;
   logic [MULT_W-1:0]  thr_mult_in;

   // latched word
   req_word_type       word_ff, word_in;

   // work registers
   logic               below_ff, below_in;
   logic               back_ff, back_in;
   logic               time_ok_ff, time_ok_in;
   logic [COOL_W-1:0]  cool_ff, cool_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   // detector state
   logic [LEVEL_W-1:0] base_ff, base_in;
   logic [LEVEL_W-1:0] peak_ff, peak_in;
   logic [TIME_W-1:0]  last_ff, last_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   // combinational terms
   logic [LEVEL_W-1:0] mul_a, mul_b, diff;
   logic [TEMPO_W-1:0] tempo_off;
   logic [14:0]        cool_x, cool_sum;
   logic [9:0]         cool_y;
   logic [23:0]        cool_q;
   logic [COOL_W-1:0]  cool_calc;
   logic [PROD_W-1:0]  round_sum;
   logic [LEVEL_W-1:0] step;
   logic [TIME_W-1:0]  elapsed;
   logic [19:0]        thr, thr_eff;
   logic               fire;

   assign status.slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_word         = rsp_word_ff;

   // register writes
   always_comb begin
      fast_drop_in   = fast_drop_ff;
      slow_rise_in   = slow_rise_ff;
      peak_decay_in  = peak_decay_ff;
      thr_mult_in    = thr_mult_ff;
      onset_floor_in = onset_floor_ff;
      min_level_in   = min_level_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_FAST_DROP:   fast_drop_in   = csr_data;
            CSR_SLOW_RISE:   slow_rise_in   = csr_data;
            CSR_PEAK_DECAY:  peak_decay_in  = csr_data;
            CSR_THR_MULT:    thr_mult_in    = csr_data[MULT_W-1:0];
            CSR_ONSET_FLOOR: onset_floor_in = csr_data;
            CSR_MIN_LEVEL:   min_level_in   = csr_data;
            default:         ;
         endcase
      end
   end

   // distance to baseline
   always_comb begin
      below_in = below_ff;
      if (cmd.mul_base) below_in = word_ff.onset_value < base_ff;
      diff = below_in ? (base_ff - word_ff.onset_value) : (word_ff.onset_value - base_ff);
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = diff;
      mul_b = below_in ? fast_drop_ff : slow_rise_ff;
      if (cmd.mul_peak) begin
         mul_a = peak_ff;
         mul_b = peak_decay_ff;
      end else if (cmd.mul_thr) begin
         mul_a = base_ff;
         mul_b = {{(LEVEL_W-MULT_W){1'b0}}, thr_mult_ff};
      end
      prod_in = prod_ff;
      if (cmd.mul_base || cmd.mul_peak || cmd.mul_thr) begin
         prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
      end
   end

   // cooldown from tempo: ceil(x / 224) = floor(floor((x + 223) / 32) / 7)
   always_comb begin
      tempo_off = word_ff.tempo_bpm - TEMPO_LO;
      cool_x    = {3'b000, tempo_off} * COOL_SLOPE;
      cool_sum  = cool_x + COOL_CEIL;
      cool_y    = cool_sum[14:5];
      cool_q    = {14'd0, cool_y} * RECIP7;
      if (word_ff.tempo_bpm <= TEMPO_LO) begin
         cool_calc = COOL_MAX;
      end else if (word_ff.tempo_bpm >= TEMPO_HI) begin
         cool_calc = COOL_MIN;
      end else begin
         cool_calc = COOL_MAX - {1'b0, cool_q[22:16]};
      end
      cool_in = cmd.mul_base ? cool_calc : cool_ff;
      back_in = back_ff;
      if (cmd.mul_base) back_in = word_ff.time_ms < last_ff;
   end

   // elapsed time check, baseline update
   always_comb begin
      elapsed    = word_ff.time_ms - last_ff;
      time_ok_in = time_ok_ff;
      if (cmd.mul_peak) time_ok_in = !back_ff && (elapsed > TIME_W'(cool_ff));
      round_sum  = prod_ff + ROUND_HALF;
      step       = round_sum[31:16];
      base_in    = base_ff;
      if (cmd.mul_peak) base_in = below_ff ? (base_ff - step) : (base_ff + step);
   end

   // peak hold update
   always_comb begin
      peak_in = peak_ff;
      if (cmd.mul_thr) begin
         peak_in = (word_ff.onset_value > peak_ff) ? word_ff.onset_value : prod_ff[31:16];
      end
   end

   // threshold, firing decision and result word
   always_comb begin
      thr     = prod_ff[27:8];
      thr_eff = (thr < 20'(onset_floor_ff)) ? 20'(onset_floor_ff) : thr;
      fire    = (word_ff.mic_level > min_level_ff) &&
                (20'(word_ff.onset_value) > thr_eff) && time_ok_ff;

      last_in      = last_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.finish) begin
         if (fire || back_ff) last_in = word_ff.time_ms;
         rsp_word_in.pulse_fired    = fire;
         rsp_word_in.pulse_strength = fire ? word_ff.onset_value : '0;
         rsp_word_in.baseline_level = base_ff;
         rsp_word_in.peak_level     = peak_ff;
         rsp_valid_in               = 1'b1;
      end
      word_in = cmd.load ? req_word : word_ff;
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      below_ff    <= below_in;
      back_ff     <= back_in;
      time_ok_ff  <= time_ok_in;
      cool_ff     <= cool_in;
      prod_ff     <= prod_in;
      rsp_word_ff <= rsp_word_in;
   end

   // control, configuration and detector state
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_drop_ff   <= FAST_DROP_RST;
         slow_rise_ff   <= SLOW_RISE_RST;
         peak_decay_ff  <= PEAK_DECAY_RST;
         thr_mult_ff    <= THR_MULT_RST;
         onset_floor_ff <= ONSET_FLOOR_RST;
         min_level_ff   <= MIN_LEVEL_RST;
         base_ff        <= '0;
         peak_ff        <= '0;
         last_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         fast_drop_ff   <= fast_drop_in;
         slow_rise_ff   <= slow_rise_in;
         peak_decay_ff  <= peak_decay_in;
         thr_mult_ff    <= thr_mult_in;
         onset_floor_ff <= onset_floor_in;
         min_level_ff   <= min_level_in;
         base_ff        <= base_in;
         peak_ff        <= peak_in;
         last_ff        <= last_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_fired_strength: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.pulse_fired |-> rsp_word_ff.pulse_strength != '0)
      else $error("pulse fired with zero strength");

   a_quiet_strength: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_word_ff.pulse_fired |-> rsp_word_ff.pulse_strength == '0)
      else $error("strength reported without a pulse");

   a_last_pulse: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && fire |=> last_ff == $past(word_ff.time_ms))
      else $error("last pulse time not taken on a pulse");

   a_cool_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_base |=> (cool_ff >= COOL_MIN) && (cool_ff <= COOL_MAX))
      else $error("cooldown out of range");
`endif

endmodule

[hw/rtl/adaptive_onset_pulse_detector.sv]
// adaptive_onset_pulse_detector: top level, joins the sequencer and the datapath.
// Depends on aopd_pkg, aopd_if, aopd_ctrl and aopd_datapath.
//
// Usage:
//   req_if carries one frame word: onset value, mic level, ms timestamp, tempo.
//   rsp_if returns one word per frame: pulse flag, strength, baseline, peak.
//   csr_if writes one of six registers by index; ready is always high and
//   writes to unused indexes are dropped. Write registers only while idle.
// Sequence: an accepted frame steps through ST_MBASE, ST_MPEAK, ST_MTHR and ST_FIN.
//   The single 16x16 multiplier is used three times per frame (baseline step,
//   peak decay, threshold), then ST_FIN compares and loads the output register
//   while taking the next frame.
// Reset (synchronous, active high) loads the register defaults and clears
//   baseline, peak hold and last pulse time.
// Stall: the output register holds its word until taken; the frame behind it
//   waits in its last step, and req_if.ready stays low until the register drains.
module adaptive_onset_pulse_detector import aopd_pkg::*; (
   input logic       clock,
   input logic       reset,
   aopd_req_if.sink   req_if,
   aopd_rsp_if.source rsp_if,
   aopd_csr_if.sink   csr_if
);

   cmd_type      cmd;
   status_type   status;
   req_word_type req_word;
   rsp_word_type rsp_word;
   logic         req_ready;
   logic         rsp_valid;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = req_ready;

   assign req_word.onset_value = req_if.onset_value;
   assign req_word.mic_level   = req_if.mic_level;
   assign req_word.time_ms     = req_if.time_ms;
   assign req_word.tempo_bpm   = req_if.tempo_bpm;

   assign rsp_if.valid          = rsp_valid;
   assign rsp_if.pulse_fired    = rsp_word.pulse_fired;
   assign rsp_if.pulse_strength = rsp_word.pulse_strength;
   assign rsp_if.baseline_level = rsp_word.baseline_level;
   assign rsp_if.peak_level     = rsp_word.peak_level;

   aopd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   aopd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_word),
      .csr_write (csr_if.valid),
      .csr_index (csr_if.index),
      .csr_data  (csr_if.data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .rsp_word  (rsp_word)
   );

endmodule

[tb/sv/adaptive_onset_pulse_detector_tb.sv]
`timescale 1ns / 100ps
// adaptive_onset_pulse_detector_tb: self-checking bench for the onset pulse detector.
// Walks a directed frame table, then random frames under several register settings.
// Depends on aopd_pkg, aopd_if and the adaptive_onset_pulse_detector RTL.
module adaptive_onset_pulse_detector_tb;
   import aopd_pkg::*;

   localparam int IDLE_LIMIT = 2000;   // cycles with no handshake before giving up
   localparam int HOLD_CYCLES = 300;   // long receiver hold-off
   localparam int SETTLE_CYCLES = 8;   // settle time after the last result word

   // indexes past the register list, writes there are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_type;

   typedef struct packed {
      req_word_type frame;
      logic         pinned;   // result typed in below, else predicted
      rsp_word_type result;
   } directed_row_type;

   logic clock;
   logic reset;

   aopd_req_if req_if ();
   aopd_rsp_if rsp_if ();
   aopd_csr_if csr_if ();

   adaptive_onset_pulse_detector dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // predictor registers and state
   logic [LEVEL_W-1:0] fast_drop_q, slow_rise_q, peak_decay_q, onset_floor_q, min_level_q;
   logic [MULT_W-1:0]  thr_mult_q;
   logic [LEVEL_W-1:0] baseline_q, peak_hold_q;
   logic [TIME_W-1:0]  last_pulse_q;

   rsp_word_type frame_results_due [$];
   rsp_word_type pinned_results [int];
   int  sent_frames = 0;
   int  accepted_frames = 0;
   int  fail_count = 0;
   int  idle_cycles = 0;
   int  burst_left = 1;
   bit  hold_armed = 1'b0;

   // directed frames, run under the reset register values
   directed_row_type directed_rows [23] = '{
      // all zero right after reset: nothing moves
      '{'{16'h0000, 16'h0000, 32'd0, 12'd0}, 1'b1, '{1'b0, 16'h0000, 16'd0, 16'h0000}},
      // full-scale onset: slow rise step of 1311, peak jumps, fires
      '{'{16'hFFFF, 16'hFFFF, 32'd1000, 12'd0}, 1'b1, '{1'b1, 16'hFFFF, 16'd1311, 16'hFFFF}},
      // slow tempo cooldown edge: 150 ms exactly does not fire, 151 does
      '{'{16'hFFFF, 16'hFFFF, 32'd1150, 12'd0}, 1'b0, '0},
      '{'{16'hFFFF, 16'hFFFF, 32'd1151, 12'd0}, 1'b0, '0},
      // fast tempo cooldown edge at 40 ms
      '{'{16'hFFFF, 16'hFFFF, 32'd1191, 12'hFFF}, 1'b0, '0},
      '{'{16'hFFFF, 16'hFFFF, 32'd1192, 12'hFFF}, 1'b0, '0},
      // tempo around the ramp ends and in the middle
      '{'{16'hC000, 16'h8000, 32'd1342, 12'd960}, 1'b0, '0},
      '{'{16'hC000, 16'h8000, 32'd1343, 12'd961}, 1'b0, '0},
      '{'{16'hC000, 16'h8000, 32'd1500, 12'd2000}, 1'b0, '0},
      '{'{16'hC000, 16'h8000, 32'd1600, 12'd3199}, 1'b0, '0},
      '{'{16'hC000, 16'h8000, 32'd1700, 12'd3200}, 1'b0, '0},
      // onset drops: fast baseline fall, peak decay
      '{'{16'h0000, 16'hFFFF, 32'd1800, 12'hFFF}, 1'b0, '0},
      '{'{16'h0000, 16'hFFFF, 32'd1900, 12'hFFF}, 1'b0, '0},
      // mic level equal to the minimum does not fire, one above does
      '{'{16'h8000, 16'd1966, 32'd2000, 12'hFFF}, 1'b0, '0},
      '{'{16'h8000, 16'd1967, 32'd2100, 12'hFFF}, 1'b0, '0},
      // timestamp steps back: last pulse time follows it
      '{'{16'hFFFF, 16'hFFFF, 32'd5, 12'hFFF}, 1'b0, '0},
      '{'{16'hFFFF, 16'hFFFF, 32'd46, 12'hFFF}, 1'b0, '0},
      '{'{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 12'hFFF}, 1'b0, '0},
      '{'{16'd6554, 16'hFFFF, 32'hFFFF_FFFF, 12'hFFF}, 1'b0, '0},
      '{'{16'h0000, 16'h0000, 32'd0, 12'd0}, 1'b0, '0},
      // onset at the floor
      '{'{16'd6554, 16'hFFFF, 32'd200, 12'hFFF}, 1'b0, '0},
      // alternating bit patterns
      '{'{16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 12'hAAA}, 1'b0, '0},
      '{'{16'h5555, 16'hAAAA, 32'h5555_5555, 12'h555}, 1'b0, '0}
   };

   // expected result of one frame; advances the predictor state
   function automatic rsp_word_type predict_frame_result(req_word_type w);
      logic [LEVEL_W-1:0] gap;
      logic [PROD_W-1:0]  prod;
      logic [27:0]        thr_full;
      logic [19:0]        thr;
      int unsigned        cool;
      int unsigned        tempo;
      logic [TIME_W-1:0]  since;
      rsp_word_type       r;

      // baseline moves toward the onset value, rounding half up
      if (w.onset_value < baseline_q) begin
         gap = baseline_q - w.onset_value;
         prod = PROD_W'(gap) * PROD_W'(fast_drop_q) + ROUND_HALF;
         baseline_q = baseline_q - prod[31:16];
      end else begin
         gap = w.onset_value - baseline_q;
         prod = PROD_W'(gap) * PROD_W'(slow_rise_q) + ROUND_HALF;
         baseline_q = baseline_q + prod[31:16];
      end

      // peak hold follows rises, otherwise decays with truncation
      if (w.onset_value > peak_hold_q) begin
         peak_hold_q = w.onset_value;
      end else begin
         prod = PROD_W'(peak_hold_q) * PROD_W'(peak_decay_q);
         peak_hold_q = prod[31:16];
      end

      // threshold from the updated baseline, never below the floor
      thr_full = 28'(baseline_q) * 28'(thr_mult_q);
      thr = thr_full[27:8];
      if (thr < 20'(onset_floor_q)) thr = 20'(onset_floor_q);

      // cooldown: 150 ms up to 60 BPM, 40 ms from 200 BPM, floor of the line between
      tempo = 32'(w.tempo_bpm);
      if (tempo <= 960) cool = 150;
      else if (tempo >= 3200) cool = 40;
      else cool = 150 - (11 * (tempo - 960) + 223) / 224;

      if (w.time_ms < last_pulse_q) last_pulse_q = w.time_ms;
      since = w.time_ms - last_pulse_q;

      r.pulse_fired = (w.mic_level > min_level_q) && (20'(w.onset_value) > thr) &&
                      (since > cool);
      if (r.pulse_fired) last_pulse_q = w.time_ms;
      r.pulse_strength = r.pulse_fired ? w.onset_value : '0;
      r.baseline_level = baseline_q;
      r.peak_level = peak_hold_q;
      return r;
   endfunction

   task automatic check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // scoreboard: register writes, frame prediction, result checks, watchdog
   always @(posedge clock) begin
      rsp_word_type want, got, calc;
      req_word_type frame;
      bit moved;

      moved = 1'b0;
      if (reset) begin
         fast_drop_q = FAST_DROP_RST;
         slow_rise_q = SLOW_RISE_RST;
         peak_decay_q = PEAK_DECAY_RST;
         thr_mult_q = THR_MULT_RST;
         onset_floor_q = ONSET_FLOOR_RST;
         min_level_q = MIN_LEVEL_RST;
         baseline_q = '0;
         peak_hold_q = '0;
         last_pulse_q = '0;
         idle_cycles = 0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            moved = 1'b1;
            case (csr_idx_type'(csr_if.index))
               CSR_FAST_DROP:   fast_drop_q = csr_if.data;
               CSR_SLOW_RISE:   slow_rise_q = csr_if.data;
               CSR_PEAK_DECAY:  peak_decay_q = csr_if.data;
               CSR_THR_MULT:    thr_mult_q = csr_if.data[MULT_W-1:0];
               CSR_ONSET_FLOOR: onset_floor_q = csr_if.data;
               CSR_MIN_LEVEL:   min_level_q = csr_if.data;
               default: ;
            endcase
         end

         if (req_if.valid && req_if.ready) begin
            moved = 1'b1;
            frame.onset_value = req_if.onset_value;
            frame.mic_level = req_if.mic_level;
            frame.time_ms = req_if.time_ms;
            frame.tempo_bpm = req_if.tempo_bpm;
            calc = predict_frame_result(frame);
            if (pinned_results.exists(accepted_frames))
               frame_results_due.push_back(pinned_results[accepted_frames]);
            else
               frame_results_due.push_back(calc);
            accepted_frames++;
         end

         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            got.pulse_fired = rsp_if.pulse_fired;
            got.pulse_strength = rsp_if.pulse_strength;
            got.baseline_level = rsp_if.baseline_level;
            got.peak_level = rsp_if.peak_level;
            if (frame_results_due.size() == 0) begin
               $display("%0t: unexpected result word %0d/%0d/%0d/%0d", $time,
                        got.pulse_fired, got.pulse_strength, got.baseline_level,
                        got.peak_level);
               fail_count++;
            end else begin
               want = frame_results_due.pop_front();
               check_field("pulse_fired", 32'(want.pulse_fired), 32'(got.pulse_fired));
               check_field("pulse_strength", 32'(want.pulse_strength),
                           32'(got.pulse_strength));
               check_field("baseline_level", 32'(want.baseline_level),
                           32'(got.baseline_level));
               check_field("peak_level", 32'(want.peak_level), 32'(got.peak_level));
            end
         end

         if (moved) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // receiver: changes its stall pattern now and then, one long hold-off on request
   initial begin : rsp_stall
      rx_mode_type mode;
      int span;
      int tick;

      mode = RX_OPEN;
      span = 0;
      tick = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_armed) begin
            hold_armed = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (span == 0) begin
            mode = rx_mode_type'($urandom_range(RX_OPEN, RX_SPARSE));
            span = $urandom_range(20, 150);
         end
         span--;
         case (mode)
            RX_OPEN:   rsp_if.ready <= 1'b1;
            RX_RANDOM: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            default:   rsp_if.ready <= (tick % 3 == 0);
         endcase
      end
   end

   // offer one frame word; valid stays up inside a burst
   task automatic send_frame(req_word_type w);
      req_if.valid <= 1'b1;
      req_if.onset_value <= w.onset_value;
      req_if.mic_level <= w.mic_level;
      req_if.time_ms <= w.time_ms;
      req_if.tempo_bpm <= w.tempo_bpm;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_frames++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         // now and then a long run with no gaps
         burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
      end
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
   endtask

   task automatic load_settings(logic [15:0] fast_drop, logic [15:0] slow_rise,
                                logic [15:0] peak_decay, logic [15:0] thr_mult,
                                logic [15:0] onset_floor, logic [15:0] min_level);
      write_register(CSR_FAST_DROP, fast_drop);
      write_register(CSR_SLOW_RISE, slow_rise);
      write_register(CSR_PEAK_DECAY, peak_decay);
      write_register(CSR_THR_MULT, thr_mult);
      write_register(CSR_ONSET_FLOOR, onset_floor);
      write_register(CSR_MIN_LEVEL, min_level);
      write_register($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO, 16'($urandom));
      csr_if.valid <= 1'b0;
   endtask

   // stop offering and wait until every result word has come back
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (accepted_frames != sent_frames || frame_results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // frames with a mostly advancing clock, noisy onset and occasional spikes
   task automatic random_frames(int count, logic [TIME_W-1:0] start_ms, bit long_hold);
      req_word_type w;
      logic [TIME_W-1:0] now;
      int pick;

      now = start_ms;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) now = now + $urandom_range(0, 60);
         else if (pick < 92) now = now + $urandom_range(100, 400);
         else if (pick < 96) now = now - $urandom_range(1, 1000);
         else now = $urandom;

         pick = $urandom_range(0, 99);
         if (pick < 65) w.onset_value = 16'($urandom_range(0, 16'h1800));
         else if (pick < 95) w.onset_value = 16'($urandom_range(16'h1800, 16'hFFFF));
         else w.onset_value = 16'($urandom);

         if ($urandom_range(0, 99) < 85)
            w.mic_level = 16'($urandom_range(16'h0800, 16'hFFFF));
         else
            w.mic_level = 16'($urandom_range(0, 16'h0900));

         if ($urandom_range(0, 99) < 60) w.tempo_bpm = 12'($urandom_range(900, 3300));
         else w.tempo_bpm = 12'($urandom_range(0, 4095));

         w.time_ms = now;
         // receiver goes quiet while frames keep coming
         if (long_hold && i == 10) begin
            hold_armed = 1'b1;
            burst_left = 50;
         end
         send_frame(w);
      end
   endtask

   // stimulus
   initial begin : stimulus
      reset = 1'b1;
      req_if.valid <= 1'b0;
      req_if.onset_value <= '0;
      req_if.mic_level <= '0;
      req_if.time_ms <= '0;
      req_if.tempo_bpm <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= CSR_FAST_DROP;
      csr_if.data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].pinned) pinned_results[sent_frames] = directed_rows[i].result;
         send_frame(directed_rows[i].frame);
      end
      drain_results();

      // everything zero: threshold zero, fires on any nonzero onset with a nonzero mic level once cooled down
      load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      random_frames(80, 32'd0, 1'b0);
      drain_results();

      // everything at full scale; multiplier upper bits are dropped
      load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_frames(80, $urandom, 1'b0);
      drain_results();

      // working settings so pulses fire, with the long receiver hold-off
      load_settings(16'($urandom_range(8000, 30000)), 16'($urandom_range(200, 3000)),
                    16'($urandom_range(50000, 65535)), 16'($urandom_range(256, 1024)),
                    16'($urandom_range(2000, 9000)), 16'($urandom_range(500, 4000)));
      random_frames(90, $urandom_range(0, 100000), 1'b1);
      drain_results();

      repeat (2) begin
         load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom));
         random_frames(75, $urandom, 1'b0);
         drain_results();
      end

      load_settings(FAST_DROP_RST, SLOW_RISE_RST, PEAK_DECAY_RST, 16'(THR_MULT_RST),
                    ONSET_FLOOR_RST, MIN_LEVEL_RST);
      random_frames(80, 32'hFFFF_F000, 1'b0);
      drain_results();

      if (fail_count == 0 && frame_results_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
